// File: hw/rtl/tdbm_pkg.sv
package tdbm_pkg;

  // map geometry
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int BYTE_BITS   = 8;
  localparam int STORE_BYTES = (MAX_ROWS * MAX_COLS + BYTE_BITS - 1) / BYTE_BITS;

  // widths
  localparam int MODE_W      = 3;
  localparam int IDX_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int BIT_ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int BYTE_ADDR_W = $clog2(STORE_BYTES);
  localparam int BYTE_CNT_W  = $clog2(STORE_BYTES + 1);
  localparam int SEL_W       = $clog2(BYTE_BITS);
  localparam int AREA_W      = 2 * SIZE_W;

  // request codes
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TAS    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ANY    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } req_t;

  typedef struct packed {
    logic bit_value;
    logic any_set;
    logic index_error;
  } rsp_t;

  // decoded position of one bit
  typedef struct packed {
    logic                   in_range;
    logic [BYTE_ADDR_W-1:0] byte_addr;
    logic [SEL_W-1:0]       bit_sel;
  } loc_t;

  // single-port store access
  typedef struct packed {
    logic                   we;
    logic [BYTE_ADDR_W-1:0] addr;
    logic [BYTE_BITS-1:0]   wdata;
  } mem_req_t;

endpackage

// File: hw/rtl/tdbm_store.sv
module tdbm_store (
  input  logic                                clk,
  input  tdbm_pkg::mem_req_t                  mem_req,
  output logic [tdbm_pkg::BYTE_BITS-1:0]      rdata
);

  logic [tdbm_pkg::BYTE_BITS-1:0] mem [tdbm_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
    rdata <= mem[mem_req.addr];
  end

endmodule

// File: hw/rtl/tdbm_addr.sv
module tdbm_addr (
  input  logic [tdbm_pkg::IDX_W-1:0]      row,
  input  logic [tdbm_pkg::IDX_W-1:0]      col,
  input  logic [tdbm_pkg::SIZE_W-1:0]     rows_in_use,
  input  logic [tdbm_pkg::SIZE_W-1:0]     cols_in_use,
  output tdbm_pkg::loc_t                  loc,
  output logic [tdbm_pkg::BYTE_CNT_W-1:0] byte_count
);

  logic [tdbm_pkg::BIT_ADDR_W-1:0] bit_addr;
  logic [tdbm_pkg::AREA_W-1:0]     area;
  logic [tdbm_pkg::AREA_W-1:0]     area_up;

  // row-major bit address, only meaningful when in range
  assign bit_addr = tdbm_pkg::BIT_ADDR_W'(row) * tdbm_pkg::BIT_ADDR_W'(cols_in_use)
                  + tdbm_pkg::BIT_ADDR_W'(col);

  assign loc.in_range  = (tdbm_pkg::SIZE_W'(row) < rows_in_use) &&
                         (tdbm_pkg::SIZE_W'(col) < cols_in_use);
  assign loc.byte_addr = tdbm_pkg::BYTE_ADDR_W'(bit_addr >> tdbm_pkg::SEL_W);
  assign loc.bit_sel   = bit_addr[tdbm_pkg::SEL_W-1:0];

  // bytes in use, rounded up
  assign area       = tdbm_pkg::AREA_W'(rows_in_use) * tdbm_pkg::AREA_W'(cols_in_use);
  assign area_up    = area + tdbm_pkg::AREA_W'(tdbm_pkg::BYTE_BITS - 1);
  assign byte_count = tdbm_pkg::BYTE_CNT_W'(area_up >> tdbm_pkg::SEL_W);

endmodule

// File: hw/rtl/tdbm_ctrl.sv
module tdbm_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  tdbm_pkg::req_t                      req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output tdbm_pkg::rsp_t                      rsp_data,
  input  tdbm_pkg::loc_t                      loc,
  input  logic [tdbm_pkg::BYTE_CNT_W-1:0]     byte_count,
  output tdbm_pkg::mem_req_t                  mem_req,
  input  logic [tdbm_pkg::BYTE_BITS-1:0]      rdata
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_CLR,
    ST_DONE
  } state_t;

  localparam logic [tdbm_pkg::BYTE_CNT_W-1:0] LAST_BYTE =
    tdbm_pkg::BYTE_CNT_W'(tdbm_pkg::STORE_BYTES - 1);

  state_t                              state;
  logic [tdbm_pkg::BYTE_CNT_W-1:0]     cnt;
  logic [tdbm_pkg::MODE_W-1:0]         op;
  logic [tdbm_pkg::BYTE_ADDR_W-1:0]    baddr;
  logic [tdbm_pkg::SEL_W-1:0]          sel;
  tdbm_pkg::rsp_t                      res;

  logic                                fin;
  tdbm_pkg::rsp_t                      fin_res;
  logic                                out_free;
  logic                                point_op;
  logic [tdbm_pkg::BYTE_BITS-1:0]      mask;
  logic [tdbm_pkg::BYTE_BITS-1:0]      new_byte;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign point_op  = (req_data.mode <= tdbm_pkg::MODE_TOGGLE);
  assign mask      = tdbm_pkg::BYTE_BITS'(1) << sel;

  // modified byte for the write-back
  always_comb begin
    case (op)
      tdbm_pkg::MODE_SET, tdbm_pkg::MODE_TAS: new_byte = rdata | mask;
      tdbm_pkg::MODE_TOGGLE:                  new_byte = rdata ^ mask;
      default:                                new_byte = rdata;
    endcase
  end

  // store port
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = loc.byte_addr;
    mem_req.wdata = '0;
    unique case (state)
      ST_INIT, ST_CLR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = cnt[tdbm_pkg::BYTE_ADDR_W-1:0];
      end
      ST_IDLE: begin
        if (req_data.mode == tdbm_pkg::MODE_ANY) begin
          mem_req.addr = '0;
        end
      end
      ST_RMW: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = baddr;
        mem_req.wdata = new_byte;
      end
      ST_SCAN: begin
        mem_req.addr = cnt[tdbm_pkg::BYTE_ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  // end of an item and its result
  always_comb begin
    fin     = 1'b0;
    fin_res = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (point_op && !loc.in_range) begin
            fin                 = 1'b1;
            fin_res.index_error = 1'b1;
          end else if (req_data.mode > tdbm_pkg::MODE_CLEAR) begin
            fin = 1'b1;
          end
        end
      end
      ST_RMW: begin
        fin = 1'b1;
        if (op == tdbm_pkg::MODE_READ || op == tdbm_pkg::MODE_TAS) begin
          fin_res.bit_value = rdata[sel];
        end
      end
      ST_SCAN: begin
        // rdata holds byte cnt-1
        if (rdata != '0) begin
          fin             = 1'b1;
          fin_res.any_set = 1'b1;
        end else if (cnt == byte_count) begin
          fin = 1'b1;
        end
      end
      ST_CLR: begin
        fin = (cnt == byte_count - tdbm_pkg::BYTE_CNT_W'(1));
      end
      ST_DONE: begin
        fin     = 1'b1;
        fin_res = res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (fin && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          cnt <= cnt + tdbm_pkg::BYTE_CNT_W'(1);
          if (cnt == LAST_BYTE) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op    <= req_data.mode;
            baddr <= loc.byte_addr;
            sel   <= loc.bit_sel;
            if (req_data.mode == tdbm_pkg::MODE_ANY) begin
              cnt   <= tdbm_pkg::BYTE_CNT_W'(1);
              state <= ST_SCAN;
            end else if (req_data.mode == tdbm_pkg::MODE_CLEAR) begin
              cnt   <= '0;
              state <= ST_CLR;
            end else if (point_op && loc.in_range) begin
              state <= ST_RMW;
            end
          end
        end
        ST_SCAN: begin
          if (!fin) begin
            cnt <= cnt + tdbm_pkg::BYTE_CNT_W'(1);
          end
        end
        ST_CLR: begin
          cnt <= cnt + tdbm_pkg::BYTE_CNT_W'(1);
        end
        default: ;
      endcase
      if (fin) begin
        if (out_free) begin
          rsp_data  <= fin_res;
          state     <= ST_IDLE;
        end else begin
          res   <= fin_res;
          state <= ST_DONE;
        end
      end
    end
  end

  // store is written only by the sweeps and the write-back
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ST_INIT || state == ST_RMW || state == ST_CLR))
    else $error("store written outside a write state");

  // a read-modify-write always finishes in the next cycle, back to idle or to done
  a_rmw_one: assert property (@(posedge clk) disable iff (rst)
    state == ST_RMW |=> (state == ST_IDLE || state == ST_DONE))
    else $error("read-modify-write did not finish");

  // the scan never runs past the bytes in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> (cnt != '0 && cnt <= byte_count))
    else $error("scan counter out of bounds");

  // a new result only follows the end of an item
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(fin))
    else $error("result raised without a finished item");

endmodule

// File: hw/rtl/two_d_bit_map.sv
// Row-by-column bit map held in a 512-byte single-port store with a registered
// read. A bit at (row, col) lives at address row * cols_in_use + col, byte
// address / 8, bit address % 8 from the least significant end. Point requests
// (read, set, test-and-set, toggle) read the byte in the cycle they are taken,
// then write the modified byte back through the same port. Any-set reads the
// byte_count bytes in use in order and stops at the first non-zero byte; clear
// zeroes them, one byte written per cycle, where byte_count is
// ceil(rows_in_use * cols_in_use / 8). Out-of-range point requests and unused
// mode codes finish with the store untouched. The result sits in an output
// register, so the next request may be taken while the last result waits.
// After reset a clearing pass writes zero to all 512 bytes, and req_stall stays
// high during that pass; configuration writes are taken at any time (cfg_ready
// is always high) but should only be issued while no request is in flight.
module two_d_bit_map (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  tdbm_pkg::req_t                     req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output tdbm_pkg::rsp_t                     rsp_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tdbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdbm_pkg::SIZE_W-1:0]        cfg_data
);

  // map size registers
  logic [tdbm_pkg::SIZE_W-1:0]     rows_in_use;
  logic [tdbm_pkg::SIZE_W-1:0]     cols_in_use;

  logic [tdbm_pkg::BYTE_CNT_W-1:0] byte_count;
  tdbm_pkg::loc_t                  loc;
  tdbm_pkg::mem_req_t              mem_req;
  logic [tdbm_pkg::BYTE_BITS-1:0]  rdata;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [tdbm_pkg::SIZE_W-1:0] clamp_size(
    input logic [tdbm_pkg::SIZE_W-1:0] value,
    input logic [tdbm_pkg::SIZE_W-1:0] max
  );
    logic [tdbm_pkg::SIZE_W-1:0] v;
    v = value;
    if (v == '0) begin
      v = tdbm_pkg::SIZE_W'(1);
    end
    if (v > max) begin
      v = max;
    end
    return v;
  endfunction

  assign cfg_ready = 1'b1;

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= tdbm_pkg::SIZE_W'(tdbm_pkg::MAX_ROWS);
      cols_in_use <= tdbm_pkg::SIZE_W'(tdbm_pkg::MAX_COLS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tdbm_pkg::CFG_ROWS:
          rows_in_use <= clamp_size(cfg_data, tdbm_pkg::SIZE_W'(tdbm_pkg::MAX_ROWS));
        tdbm_pkg::CFG_COLS:
          cols_in_use <= clamp_size(cfg_data, tdbm_pkg::SIZE_W'(tdbm_pkg::MAX_COLS));
        default: ;
      endcase
    end
  end

  // geometry: bit position of the request and bytes in use
  tdbm_addr u_addr (
    .row         (req_data.row),
    .col         (req_data.col),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .loc         (loc),
    .byte_count  (byte_count)
  );

  // sequencer: read-modify-write, scan and clear sweeps, result register
  tdbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data),
    .loc        (loc),
    .byte_count (byte_count),
    .mem_req    (mem_req),
    .rdata      (rdata)
  );

  // byte-wide bit store
  tdbm_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

endmodule
